/* src/sha256_stream_hasher_top_macros.svh */
// Assertion macros for the SHA-256 stream hasher.
// No dependencies; included inside module bodies.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH
// Implication check under reset.
`define SHA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication check under reset.
`define SHA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* src/sha_pkg.sv */
// Package for the SHA-256 stream hasher: modes, states, round constants.
// No dependencies.
package sha_pkg;
	typedef enum logic [1:0] {
		MODE_INIT = 2'd0,
		MODE_DATA = 2'd1,
		MODE_SNAP = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} out_item_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
endpackage

/* src/sha_stream_if.sv */
// Valid/ready channel interface carrying one payload item.
// Generic over the payload type; used with sha_pkg structs.
interface sha_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/sha256_stream_hasher_top.sv */
// SHA-256 stream hasher: init, append byte, snapshot digest; one shared round unit.
// Init and data bytes are taken in idle; the 64th byte of a block also runs load, rounds, fold.
// Snapshot: 1 or 2 compressions, then 8 digest items one per cycle while out_ch is ready.
// Rate set by the single round datapath: one SHA-256 round per clock.
// arst_n clears control state and loads the initial hash value; no item is
// taken until the block is back in idle.
module sha256_stream_hasher_top (
	input logic clk,
	input logic arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	import sha_pkg::*;

	// Streaming state.
	logic [31:0] hash_q [8];
	logic [63:0] bitlen_q;
	logic [5:0]  fill_q;
	// Block buffer as 16 big-endian words, written a byte at a time.
	logic [31:0] buf_q [16];

	// Compression datapath.
	logic [31:0] acc_q [8];   // hash being updated (main or snapshot copy)
	logic [31:0] v_q [8];     // working variables a..h
	logic [31:0] w_q [16];    // message window / block being compressed
	logic [5:0]  rnd_q;
	logic        snap_q;      // compression belongs to a snapshot
	logic        second_q;    // snapshot needs a second (length) block
	logic [2:0]  oidx_q;

	state_t state_q, state_d;

	logic acc_in;
	assign acc_in = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	// Padded block for a snapshot, built from the buffer and fill count.
	logic [31:0] pad_w [16];
	logic        two_blk;
	assign two_blk = (fill_q >= 6'd56);
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			for (int b = 0; b < 4; b++) begin
				logic [5:0] pos;
				pos = 6'(i * 4 + b);
				if (pos < fill_q)
					pad_w[i][31 - 8*b -: 8] = buf_q[i][31 - 8*b -: 8];
				else if (pos == fill_q)
					pad_w[i][31 - 8*b -: 8] = PAD_MARK;
				else
					pad_w[i][31 - 8*b -: 8] = 8'h00;
			end
		end
		if (!two_blk) begin
			pad_w[14] = bitlen_q[63:32];
			pad_w[15] = bitlen_q[31:0];
		end
	end

	// One round: schedule word and state update.
	logic [31:0] wt, x15, x2, sg0, sg1, e, a, big1, chs, p1, big0, mj;
	always_comb begin
		x15 = w_q[1];
		x2  = w_q[14];
		sg0 = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
		sg1 = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
		wt  = (rnd_q < 6'd16) ? w_q[0] : (w_q[0] + sg0 + w_q[9] + sg1);
		e = v_q[4];
		a = v_q[0];
		big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		chs  = (e & v_q[5]) ^ (~e & v_q[6]);
		p1   = v_q[7] + big1 + chs + ROUND_K[rnd_q] + wt;
		big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		mj   = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && in_ch.payload.mode == MODE_SNAP)
					state_d = ST_LOAD;
				else if (acc_in && in_ch.payload.mode == MODE_DATA && fill_q == 6'd63)
					state_d = ST_LOAD;
			end
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (!snap_q)      state_d = ST_IDLE;
				else if (second_q) state_d = ST_LOAD;
				else              state_d = ST_OUT;
			end
			ST_OUT: if (out_ch.ready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		out_ch.valid = (state_q == ST_OUT);
		out_ch.payload.digest_word = acc_q[oidx_q];
		out_ch.payload.word_index  = oidx_q;
		out_ch.payload.last        = (oidx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			for (int i = 0; i < 8; i++) hash_q[i] <= INIT_H[i];
			bitlen_q <= '0;
			fill_q   <= '0;
			rnd_q    <= '0;
			snap_q   <= 1'b0;
			second_q <= 1'b0;
			oidx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						case (in_ch.payload.mode)
							MODE_INIT: begin
								for (int i = 0; i < 8; i++) hash_q[i] <= INIT_H[i];
								bitlen_q <= '0;
								fill_q   <= '0;
							end
							MODE_DATA: begin
								bitlen_q <= bitlen_q + 64'd8;
								fill_q   <= fill_q + 6'd1;
								snap_q   <= 1'b0;
								second_q <= 1'b0;
								for (int i = 0; i < 8; i++) acc_q[i] <= hash_q[i];
							end
							MODE_SNAP: begin
								snap_q   <= 1'b1;
								second_q <= two_blk;
								for (int i = 0; i < 8; i++) acc_q[i] <= hash_q[i];
								for (int i = 0; i < 16; i++) w_q[i] <= pad_w[i];
							end
							default: ;
						endcase
					end
				end
				ST_LOAD: begin
					// Data blocks take the freshly completed buffer.
					if (!snap_q)
						for (int i = 0; i < 16; i++) w_q[i] <= buf_q[i];
					for (int i = 0; i < 8; i++) v_q[i] <= acc_q[i];
					rnd_q <= '0;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wt;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + p1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= p1 + big0 + mj;
					rnd_q <= rnd_q + 6'd1;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						acc_q[i] <= acc_q[i] + v_q[i];
						if (!snap_q) hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (second_q) begin
						// Length-only block after an overflowing pad.
						for (int i = 0; i < 14; i++) w_q[i] <= '0;
						w_q[14] <= bitlen_q[63:32];
						w_q[15] <= bitlen_q[31:0];
						second_q <= 1'b0;
					end
					oidx_q <= '0;
				end
				ST_OUT: if (out_ch.ready) oidx_q <= oidx_q + 3'd1;
				default: ;
			endcase
		end
	end

	// Byte buffer write; no reset (entries past the fill count are masked).
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in && in_ch.payload.mode == MODE_DATA)
			buf_q[fill_q[5:2]][31 - 8*fill_q[1:0] -: 8] <= in_ch.payload.data_byte;
	end

	`include "sha256_stream_hasher_top_macros.svh"
	`SHA_ASSERT_IMP(a_ready_idle, in_ch.ready, state_q == ST_IDLE)
	`SHA_ASSERT_NXT(a_round_done, state_q == ST_ROUND && rnd_q == 6'd63, state_q == ST_FOLD)
	`SHA_ASSERT_IMP(a_out_snap, out_ch.valid, snap_q && !second_q)
	`SHA_ASSERT_NXT(a_load_round, state_q == ST_LOAD, state_q == ST_ROUND && rnd_q == 6'd0)
endmodule

/* tb/sv/sha256_hash_checker.sv */
// Checker for the SHA-256 stream hasher: watches both channels, predicts digests.
// Depends on sha_pkg.
module sha256_hash_checker
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_item_t in_item,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_item,
	output int fail_count,
	output int pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] hv [8];
	logic [7:0]  blk [64];
	logic [6:0]  fill;
	logic [63:0] bit_len;
	out_item_t   digest_q [$];

	function automatic logic [31:0] ror32(logic [31:0] v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic compress(inout logic [31:0] h [8], input logic [7:0] b [64]);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] p1, p2;
		for (int t = 0; t < 16; t++)
			w[t] = {b[4*t], b[4*t+1], b[4*t+2], b[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + w[t-7]
				+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
				+ (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
		v = h;
		for (int t = 0; t < 64; t++) begin
			p1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			p2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + p1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = p1 + p2;
		end
		for (int t = 0; t < 8; t++)
			h[t] = h[t] + v[t];
	endtask

	task automatic predict_digest();
		logic [31:0] sh [8];
		logic [7:0]  pad [64];
		int n;
		out_item_t o;
		sh = hv;
		pad = blk;
		n = fill;
		pad[n] = PAD_MARK;
		n++;
		if (n > LEN_POS) begin
			while (n < 64) pad[n++] = 8'h00;
			compress(sh, pad);
			n = 0;
		end
		while (n < LEN_POS) pad[n++] = 8'h00;
		for (int k = 0; k < 8; k++)
			pad[LEN_POS + k] = bit_len[63 - 8*k -: 8];
		compress(sh, pad);
		for (int k = 0; k < 8; k++) begin
			o.digest_word = sh[k];
			o.word_index = k[2:0];
			o.last = (k == 7);
			digest_q.push_back(o);
		end
	endtask

	assign pending_words = digest_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			hv = INIT_H;
			fill = '0;
			bit_len = '0;
			for (int i = 0; i < 64; i++) blk[i] = 8'h00;
			digest_q.delete();
			fail_count = 0;
		end else begin
			// result side first; a new snapshot cannot produce in the same edge
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest item %h", out_item);
					fail_count++;
				end else begin
					e = digest_q.pop_front();
					if (e.digest_word !== out_item.digest_word) begin
						$error("digest_word expected %h actual %h", e.digest_word,
							out_item.digest_word);
						fail_count++;
					end
					if (e.word_index !== out_item.word_index) begin
						$error("word_index expected %0d actual %0d", e.word_index,
							out_item.word_index);
						fail_count++;
					end
					if (e.last !== out_item.last) begin
						$error("last expected %0d actual %0d", e.last, out_item.last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (mode_t'(in_item.mode))
					MODE_INIT: begin
						hv = INIT_H;
						fill = '0;
						bit_len = '0;
					end
					MODE_DATA: begin
						blk[fill[5:0]] = in_item.data_byte;
						bit_len = bit_len + 64'd8;
						fill++;
						if (fill == 7'd64) begin
							compress(hv, blk);
							fill = '0;
						end
					end
					MODE_SNAP: predict_digest();
					default: ;
				endcase
			end
		end
	end
endmodule

/* tb/sv/tb_sha256_stream_hasher_top.sv */
// Testbench top for the SHA-256 stream hasher: stimulus, backpressure, verdict.
// Depends on sha_pkg, sha_stream_if, sha256_hash_checker and the block itself.
module tb_sha256_stream_hasher_top;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_words;
	int   cycles;
	int   src_idle_pct;   // chance in percent that the sender idles a cycle
	int   snk_idle_pct;   // same for the receiver
	bit   snk_hold;       // long receiver hold-off, owned by its own process

	sha_stream_if #(.payload_t(in_item_t))  in_ch ();
	sha_stream_if #(.payload_t(out_item_t)) out_ch ();

	sha256_stream_hasher_top u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	sha256_hash_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL sha256_stream_hasher_top");
				$finish;
			end
		end
	end

	// Receiver: random stalls at falling edges, or a forced hold-off.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Send one item: offer at a falling edge, hold until taken at a rising edge.
	// Random idle cycles go in front of the offer, so valid stays high between
	// back-to-back items and is never dropped and raised in one step.
	task automatic send_item(input mode_t m, input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{mode: m, data_byte: b};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_bytes(input int n);
		for (int i = 0; i < n; i++)
			send_item(MODE_DATA, 8'($urandom));
	endtask

	// Park the sender until every predicted digest word has come out.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
	endtask

	// One random message: init, some bytes, one or more snapshots along the way.
	// Lengths favor the padding boundaries around 55/56 and 63/64 bytes.
	task automatic random_message();
		int len;
		int sel;
		sel = $urandom_range(9);
		if (sel < 4) len = $urandom_range(20);
		else if (sel < 8) len = 52 + $urandom_range(14);
		else len = $urandom_range(130);
		send_item(MODE_INIT, 8'($urandom));
		for (int i = 0; i < len; i++) begin
			sel = $urandom_range(99);
			if (sel < 3) send_item(MODE_SNAP, 8'($urandom));
			else if (sel < 5) send_item(MODE_NONE, 8'($urandom));
			else send_item(MODE_DATA, 8'($urandom));
		end
		send_item(MODE_SNAP, 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		snk_hold = 1'b0;
		src_idle_pct = 29;
		snk_idle_pct = 74;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: data before any init hashes from the reset value.
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'hff);
		send_item(MODE_SNAP, 8'hff);
		// Empty message, with a junk byte and unused mode that must be ignored.
		send_item(MODE_INIT, 8'hff);
		send_item(MODE_NONE, 8'h5a);
		send_item(MODE_SNAP, 8'ha5);
		// Snapshot leaves state alone: two in a row give the same digest.
		send_item(MODE_SNAP, 8'h00);
		drain();

		// Boundary lengths 55, 56, 63, 64 for the one- and two-block pad paths.
		send_item(MODE_INIT, 8'h00);
		send_bytes(55);
		send_item(MODE_SNAP, 8'h00);
		send_bytes(1);
		send_item(MODE_SNAP, 8'h00);
		send_bytes(7);
		send_item(MODE_SNAP, 8'h00);
		send_bytes(1);
		send_item(MODE_SNAP, 8'h00);
		drain();

		// Hold the receiver off long enough that snapshots back up and stall input.
		// The hold-off is timed by its own process while the sender keeps offering.
		fork
			begin
				snk_hold = 1'b1;
				repeat (600) @(negedge clk);
				snk_hold = 1'b0;
			end
		join_none
		send_item(MODE_INIT, 8'h00);
		for (int i = 0; i < 6; i++) begin
			send_bytes(3);
			send_item(MODE_SNAP, 8'h00);
		end
		drain();

		// Random phases: sender busy/receiver lazy, reversed, then full speed.
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 74 : 0;
			snk_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 29 : 0;
			for (int m = 0; m < 3; m++)
				random_message();
			drain();
		end

		in_ch.valid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0 && pending_words == 0) begin
			$display("PASS sha256_stream_hasher_top");
		end else begin
			$display("FAIL sha256_stream_hasher_top");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/sha_pkg.sv
src/sha_stream_if.sv
src/sha256_stream_hasher_top.sv
tb/sv/sha256_hash_checker.sv
tb/sv/tb_sha256_stream_hasher_top.sv
